@@ hdl/wrm_pkg.sv @@
`timescale 1ns / 1ps

package wrm_pkg;

    // ADC code width and full-scale value
    localparam int ADC_W          = 12;
    localparam int ADC_FULL_SCALE = 4095;
    localparam int ROOT_STEPS     = 12;
    localparam int ROOT_IDX_W     = 4;

    // default window depth
    localparam int MAX_WINDOW_DEF = 1024;

    // calc_mode codes
    localparam logic [1:0] MODE_LATEST = 2'd0;
    localparam logic [1:0] MODE_RMS    = 2'd1;
    localparam logic [1:0] MODE_MEAN   = 2'd2;

    // input item
    typedef struct packed {
        logic [ADC_W-1:0] sample;
        logic             is_last;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [ADC_W-1:0] value;
        logic             overflow;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic                  accept;
        logic                  load;
        logic                  div_step;
        logic                  root_step;
        logic [ROOT_IDX_W-1:0] root_idx;
        logic                  finish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic use_div;
        logic use_root;
    } dp_status_t;

    // sample count width, holds 0..max_window
    function automatic int cnt_width(int max_window);
        return $clog2(max_window + 1);
    endfunction

    // sum of samples width
    function automatic int sum_width(int max_window);
        return $clog2(longint'(max_window) * longint'(ADC_FULL_SCALE) + 64'd1);
    endfunction

    // sum of squares width, also the divider width
    function automatic int sq_width(int max_window);
        return $clog2(longint'(max_window) * longint'(ADC_FULL_SCALE)
                      * longint'(ADC_FULL_SCALE) + 64'd1);
    endfunction

endpackage

@@ hdl/wrm_ctrl.sv @@
`timescale 1ns / 1ps

module wrm_ctrl #(
    parameter int MAX_WINDOW = wrm_pkg::MAX_WINDOW_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 item_last,
    input  wrm_pkg::dp_status_t  status,
    output wrm_pkg::dp_cmd_t     cmd,
    output logic                 busy
);
    import wrm_pkg::*;

    localparam int DIV_W   = sq_width(MAX_WINDOW);
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [ROOT_IDX_W-1:0] ridx_reg, ridx_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        ridx_next  = ridx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && item_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.use_div || status.use_root)
                begin
                    state_next = ST_DIV;
                    dcnt_next  = DCNT_W'(DIV_W - 1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    if (status.use_root)
                    begin
                        state_next = ST_ROOT;
                        ridx_next  = ROOT_IDX_W'(ROOT_STEPS - 1);
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (ridx_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ridx_next = ridx_reg - 1'b1;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dcnt_reg  <= '0;
            ridx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            ridx_reg  <= ridx_next;
        end
    end

    // commands
    assign busy          = (state_reg != ST_IDLE);
    assign cmd.accept    = start && (state_reg == ST_IDLE);
    assign cmd.load      = (state_reg == ST_LOAD);
    assign cmd.div_step  = (state_reg == ST_DIV);
    assign cmd.root_step = (state_reg == ST_ROOT);
    assign cmd.root_idx  = ridx_reg;
    assign cmd.finish    = (state_reg == ST_FINISH);

    // checks
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item_last) |=> (state_reg == ST_LOAD))
        else $error("window end did not start computation");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && dcnt_reg != '0) |=> (state_reg == ST_DIV))
        else $error("divider left before last step");

    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (!cmd.finish && !busy))
        else $error("finish not followed by idle");

endmodule

@@ hdl/wrm_dp.sv @@
`timescale 1ns / 1ps

module wrm_dp #(
    parameter int MAX_WINDOW = wrm_pkg::MAX_WINDOW_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 calc_mode_we,
    input  logic [1:0]           calc_mode_data,
    input  wrm_pkg::in_item_t    item,
    input  wrm_pkg::dp_cmd_t     cmd,
    output wrm_pkg::dp_status_t  status,
    output wrm_pkg::result_t     result,
    output logic                 result_valid
);
    import wrm_pkg::*;

    localparam int CNT_W = cnt_width(MAX_WINDOW);
    localparam int SUM_W = sum_width(MAX_WINDOW);
    localparam int DIV_W = sq_width(MAX_WINDOW);
    localparam int SQ_W  = 2 * ADC_W;

    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [DIV_W-1:0] sq_reg;
    logic [ADC_W-1:0] latest_reg;
    logic             dropped_reg;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [ADC_W-1:0] root_reg, root_next;
    result_t          res_reg, res_next;
    logic             res_valid_reg;

    logic [SQ_W-1:0]  sample_sq;
    logic             has_room;
    logic [CNT_W:0]   rem_sh;
    logic             rem_ge;
    logic [ADC_W-1:0] trial;
    logic [SQ_W-1:0]  trial_sq;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LATEST;
        end
        else if (calc_mode_we)
        begin
            mode_reg <= calc_mode_data;
        end
    end

    assign status.use_div  = (mode_reg == MODE_RMS) || (mode_reg == MODE_MEAN);
    assign status.use_root = (mode_reg == MODE_RMS);

    // window accumulators
    assign sample_sq = item.sample * item.sample;
    assign has_room  = (count_reg < CNT_W'(MAX_WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            latest_reg  <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            latest_reg  <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (has_room)
            begin
                count_reg  <= count_reg + 1'b1;
                sum_reg    <= sum_reg + SUM_W'(item.sample);
                sq_reg     <= sq_reg + DIV_W'(sample_sq);
                latest_reg <= item.sample;
            end
            else
            begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per step
    assign rem_sh = {rem_reg[CNT_W-1:0], dq_reg[DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, count_reg});

    // root trial, one bit per step
    assign trial    = root_reg | (ADC_W'(1) << cmd.root_idx);
    assign trial_sq = trial * trial;

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        root_next = root_reg;
        if (cmd.load)
        begin
            rem_next  = '0;
            dq_next   = (mode_reg == MODE_RMS) ? sq_reg : DIV_W'(sum_reg);
            root_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = rem_ge ? (rem_sh - {1'b0, count_reg}) : rem_sh;
            dq_next  = {dq_reg[DIV_W-2:0], rem_ge};
        end
        else if (cmd.root_step)
        begin
            if (trial_sq <= dq_reg[SQ_W-1:0])
            begin
                root_next = trial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        root_reg <= root_next;
    end

    // result select
    always_comb
    begin
        res_next.overflow = dropped_reg;
        case (mode_reg)
            MODE_LATEST: res_next.value = latest_reg;
            MODE_RMS:    res_next.value = root_reg;
            MODE_MEAN:   res_next.value = dq_reg[ADC_W-1:0];
            default:     res_next.value = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.finish;
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(MAX_WINDOW)))
        else $error("sample count above window depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == '0 && !dropped_reg && result_valid))
        else $error("window not cleared on result transfer");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !has_room) |=> dropped_reg)
        else $error("drop flag missed on full window");

endmodule

@@ hdl/window_rms_mean_last.sv @@
`timescale 1ns / 1ps
// The result strobe follows the finish state: mean and RMS pass through the divider, RMS
// then through the square root, and latest-sample mode goes from load straight to finish;
// DIV_W (34 at 1024) is the width of the bit-serial divider, and the square root has 12 steps.
// Throughput: one sample per cycle while busy is low; busy is high from window end to the strobe.
// Reset clears all window state and calc_mode to latest-sample; the receiver cannot stall.
module window_rms_mean_last #(
    parameter int MAX_WINDOW = wrm_pkg::MAX_WINDOW_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wrm_pkg::in_item_t  item,
    input  logic               calc_mode_we,
    input  logic [1:0]         calc_mode_data,
    output wrm_pkg::result_t   result,
    output logic               result_valid
);
    import wrm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    wrm_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_last (item.is_last),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // accumulators, divider and root unit
    wrm_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .calc_mode_we   (calc_mode_we),
        .calc_mode_data (calc_mode_data),
        .item           (item),
        .cmd            (cmd),
        .status         (status),
        .result         (result),
        .result_valid   (result_valid)
    );

endmodule

@@ tb/sv/window_stats_checker.sv @@
`timescale 1ns / 1ps

module window_stats_checker #(
    parameter int MAX_WINDOW = wrm_pkg::MAX_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  wrm_pkg::in_item_t item,
    input  logic              calc_mode_we,
    input  logic [1:0]        calc_mode_data,
    input  wrm_pkg::result_t  result,
    input  logic              result_valid,
    output int                mismatches,
    output int                outstanding
);

    import wrm_pkg::*;

    localparam int CNT_W = cnt_width(MAX_WINDOW);
    localparam int SUM_W = sum_width(MAX_WINDOW);
    localparam int SQ_W  = sq_width(MAX_WINDOW);

    // predicted window state
    logic [1:0]       stat_mode;
    logic [SUM_W-1:0] acc_sum;
    logic [SQ_W-1:0]  acc_squares;
    logic [CNT_W-1:0] acc_count;
    logic [ADC_W-1:0] held_sample;
    logic             samples_dropped;

    // statistics still to come out of the block, oldest first
    result_t expected_stats[$];

    initial mismatches = 0;
    initial outstanding = 0;

    task automatic note_failure(input string msg);
        $display("%0t ns  window check: %s", $time, msg);
        mismatches++;
    endtask

    // floor of the square root, one result bit per trial from the top down
    function automatic logic [ADC_W-1:0] floor_root(input logic [SQ_W-1:0] m);
        logic [ADC_W-1:0] root;
        logic [ADC_W-1:0] trial;
        root = '0;
        for (int b = ADC_W - 1; b >= 0; b--)
        begin
            trial = root | (ADC_W'(1) << b);
            if (longint'(trial) * longint'(trial) <= longint'(m))
                root = trial;
        end
        return root;
    endfunction

    // statistic selected by the mode for the window just closed
    function automatic logic [ADC_W-1:0] window_stat();
        case (stat_mode)
            MODE_LATEST: return held_sample;
            MODE_RMS:    return (acc_count != 0) ? floor_root(acc_squares / acc_count) : '0;
            MODE_MEAN:   return (acc_count != 0) ? ADC_W'(acc_sum / acc_count) : '0;
            default:     return '0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            stat_mode       = MODE_LATEST;
            acc_sum         = '0;
            acc_squares     = '0;
            acc_count       = '0;
            held_sample     = '0;
            samples_dropped = 1'b0;
            expected_stats.delete();
            outstanding <= 0;
        end
        else
        begin
            // register write
            if (calc_mode_we)
                stat_mode = calc_mode_data;

            // result transfer: compare with the oldest prediction
            if (result_valid)
            begin
                got = result;
                if (expected_stats.size() == 0)
                    note_failure($sformatf("unexpected result value=%0d overflow=%0b",
                                           got.value, got.overflow));
                else
                begin
                    want = expected_stats.pop_front();
                    if (got.value !== want.value)
                        note_failure($sformatf("value %0d, expected %0d",
                                               got.value, want.value));
                    if (got.overflow !== want.overflow)
                        note_failure($sformatf("overflow %0b, expected %0b",
                                               got.overflow, want.overflow));
                end
            end

            // sample transfer: accumulate unless the window is full
            if (start && !busy)
            begin
                if (acc_count < MAX_WINDOW)
                begin
                    acc_sum     = acc_sum + SUM_W'(item.sample);
                    acc_squares = acc_squares + SQ_W'(item.sample) * SQ_W'(item.sample);
                    acc_count   = acc_count + 1'b1;
                    held_sample = item.sample;
                end
                else
                    samples_dropped = 1'b1;

                if (item.is_last)
                begin
                    want.value    = window_stat();
                    want.overflow = samples_dropped;
                    expected_stats.push_back(want);
                    acc_sum         = '0;
                    acc_squares     = '0;
                    acc_count       = '0;
                    held_sample     = '0;
                    samples_dropped = 1'b0;
                end
            end

            outstanding <= expected_stats.size();
        end
    end

endmodule

@@ tb/sv/tb_window_rms_mean_last.sv @@
`timescale 1ns / 1ps

module tb_window_rms_mean_last;

    import wrm_pkg::*;

    // unused mode code, still legal in the 2-bit register
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 12;
    localparam int SETTLE_CYCLES = 64;   // covers the RMS path
    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEM_W       = $bits(in_item_t);

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       start          = 1'b0;
    logic       busy;
    in_item_t   item           = '0;
    logic       calc_mode_we   = 1'b0;
    logic [1:0] calc_mode_data = '0;
    result_t    result;
    logic       result_valid;

    int mismatches;
    int outstanding;
    int cycles = 0;

    window_rms_mean_last u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .calc_mode_we   (calc_mode_we),
        .calc_mode_data (calc_mode_data),
        .result         (result),
        .result_valid   (result_valid)
    );

    window_stats_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .calc_mode_we   (calc_mode_we),
        .calc_mode_data (calc_mode_data),
        .result         (result),
        .result_valid   (result_valid),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_window_rms_mean_last: done, errors");
            $finish;
        end
    end

    // sample with extra weight on the code extremes
    function automatic logic [ADC_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ADC_W'(ADC_FULL_SCALE);
            default: return ADC_W'($urandom_range(ADC_FULL_SCALE));
        endcase
    endfunction

    // one sample transfer, with random idle cycles in front; busy is sampled pre-edge
    task automatic send_sample(input logic [ADC_W-1:0] s, input logic last,
                               input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item  <= in_item_t'(ITEM_W'($urandom));
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{s, last};
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and hold off until every predicted result is out
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        calc_mode_we   <= 1'b1;
        calc_mode_data <= m;
        @(posedge clk);
        calc_mode_we   <= 1'b0;
        calc_mode_data <= 2'($urandom);
    endtask

    // len samples, the last one closing the window; full_scale forces 4095 throughout
    task automatic send_window(input int len, input int idle_pct, input bit full_scale);
        for (int i = 0; i < len; i++)
            send_sample(full_scale ? ADC_W'(ADC_FULL_SCALE) : pick_sample(),
                        i == len - 1, idle_pct);
    endtask

    // full-scale window filled to depth, then extra samples that get dropped
    task automatic send_overfull_window(input int extra, input int idle_pct);
        for (int i = 0; i < MAX_WINDOW_DEF; i++)
            send_sample(ADC_W'(ADC_FULL_SCALE), 1'b0, idle_pct);
        for (int i = 0; i < extra; i++)
            send_sample(pick_sample(), i == extra - 1, idle_pct);
    endtask

    int idle_plan[NUM_PHASES] = '{0, 60, 35, 0, 60, 35, 0, 60};

    initial
    begin
        int sent;
        int len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: latest-sample mode straight out of reset
        send_sample(12'd0, 1'b1, 0);
        send_sample(ADC_W'(ADC_FULL_SCALE), 1'b1, 0);
        send_sample(ADC_W'(ADC_FULL_SCALE), 1'b0, 0);
        send_sample(12'd0, 1'b0, 0);
        send_sample(12'd123, 1'b1, 0);
        drain_results();

        // directed: RMS at full scale, zero, small values
        write_mode(MODE_RMS);
        send_sample(ADC_W'(ADC_FULL_SCALE), 1'b0, 0);
        send_sample(ADC_W'(ADC_FULL_SCALE), 1'b1, 0);
        send_sample(12'd0, 1'b1, 0);
        send_sample(12'd1, 1'b0, 0);
        send_sample(12'd2, 1'b0, 0);
        send_sample(12'd3, 1'b0, 0);
        send_sample(12'd4, 1'b1, 0);
        drain_results();

        // directed: mean with rounding down
        write_mode(MODE_MEAN);
        send_sample(ADC_W'(ADC_FULL_SCALE), 1'b0, 0);
        send_sample(12'd4094, 1'b1, 0);
        send_sample(12'd0, 1'b0, 0);
        send_sample(ADC_W'(ADC_FULL_SCALE), 1'b1, 0);
        drain_results();

        // directed: unused mode still gives a result, value zero
        write_mode(MODE_UNUSED);
        send_sample(12'd2048, 1'b0, 0);
        send_sample(12'd2048, 1'b1, 0);
        drain_results();

        // random phases, one mode setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_mode(2'(p % 4));

            // one window past depth: largest sum of squares, then dropped samples
            if (p == 1)
                send_overfull_window(1 + $urandom_range(3), idle_plan[p]);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 32)
                                               : $urandom_range(1, 8);
                send_window(len, idle_plan[p], $urandom_range(19) == 0);
                sent += len;
                if ($urandom_range(11) == 0)
                    drain_results();
            end
            drain_results();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("tb_window_rms_mean_last: done, clean");
        else
            $display("tb_window_rms_mean_last: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/wrm_pkg.sv
hdl/wrm_ctrl.sv
hdl/wrm_dp.sv
hdl/window_rms_mean_last.sv
tb/sv/window_stats_checker.sv
tb/sv/tb_window_rms_mean_last.sv
